[design/pccal_pkg.sv]
// Shared types, codes and constants for the per-channel polynomial calibration block.
// Used by every module of the block and by its port checker.
package pccal_pkg;

    // Fixed field widths
    localparam int DET_W     = 4;
    localparam int STRIP_W   = 6;
    localparam int CHAN_W    = STRIP_W + 1;
    localparam int RAW_W     = 16;
    localparam int COEF_W    = 48;
    localparam int RES_W     = 48;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 2;

    // Coefficient split used for the wide products
    localparam int HALF_W    = COEF_W / 2;
    localparam int X2_W      = 2 * RAW_W;
    localparam int X3_W      = 3 * RAW_W;

    // Accumulator: cube term is 96 bits signed, four terms summed
    localparam int ACC_W     = 100;

    // Default parameter values
    localparam int DEF_NUM_DETECTORS    = 8;
    localparam int DEF_NUM_STRIPS       = 32;
    localparam int DEF_COEFF_FRAC_BITS  = 40;
    localparam int DEF_RESULT_FRAC_BITS = 16;

    // Strip weave constants
    localparam int WEAVE_DET_LIMIT = 4;   // detectors below this are board-interleaved
    localparam int WEAVE_OFFSET    = 16;  // upper half of a board
    localparam int BACK_DET        = 4;   // detector with back-side reversal
    localparam int BACK_STRIPS     = 8;   // strips reversed on the back side
    localparam int BACK_TOP        = 7;   // highest reversed strip

    // Saturation limits
    localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLY_ORDER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEAVE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK_WEAVE  = 2'd2;

    // Polynomial orders
    localparam logic [1:0] ORDER_NONE   = 2'd0;
    localparam logic [1:0] ORDER_LINEAR = 2'd1;
    localparam logic [1:0] ORDER_SQUARE = 2'd2;
    localparam logic [1:0] ORDER_CUBE   = 2'd3;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENERGY = 2'd1,
        OP_TIME   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_REMAP = 2'd2,
        ST_SAT   = 2'd3
    } status_t;

    // Per-item control carried down the pipeline
    typedef struct packed {
        logic    calc;      // result comes from the arithmetic
        status_t status;    // status when calc is low
        logic    energy;    // polynomial, else time
        logic    use_sq;
        logic    use_cube;
    } ctl_t;

    // One table entry
    typedef struct packed {
        logic [COEF_W-1:0] intercept;
        logic [COEF_W-1:0] slope;
        logic [COEF_W-1:0] square;
        logic [COEF_W-1:0] cube;
    } coef_entry_t;

endpackage

[design/pccal_front.sv]
// Input decode, strip weave remap and the coefficient memory.
// Depends on pccal_pkg.
module pccal_front #(
    parameter int NUM_DETECTORS = pccal_pkg::DEF_NUM_DETECTORS,
    parameter int NUM_STRIPS    = pccal_pkg::DEF_NUM_STRIPS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [1:0]                   op,
    input  logic [pccal_pkg::DET_W-1:0]   detector,
    input  logic [pccal_pkg::STRIP_W-1:0] strip,
    input  logic [pccal_pkg::RAW_W-1:0]   raw_channel,
    input  logic [pccal_pkg::COEF_W-1:0]  load_intercept,
    input  logic [pccal_pkg::COEF_W-1:0]  load_slope,
    input  logic [pccal_pkg::COEF_W-1:0]  load_square,
    input  logic [pccal_pkg::COEF_W-1:0]  load_cube,
    input  logic [1:0]                   poly_order,
    input  logic                         weave_enable,
    input  logic                         back_weave_enable,
    output logic                         s1_valid,
    output pccal_pkg::ctl_t              s1_ctl,
    output logic [pccal_pkg::RAW_W-1:0]   s1_x,
    output logic [pccal_pkg::X2_W-1:0]    s1_x2,
    output pccal_pkg::coef_entry_t       s1_coef
);
    import pccal_pkg::*;

    localparam int DEPTH = NUM_DETECTORS * NUM_STRIPS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [DET_W:0]  ND_L = (DET_W + 1)'(NUM_DETECTORS);
    localparam logic [CHAN_W-1:0] NS_L = CHAN_W'(NUM_STRIPS);

    coef_entry_t coef_mem [DEPTH];
    coef_entry_t rd_data_reg;

    op_t               op_c;
    logic              in_range;
    logic [CHAN_W-1:0] chan;
    logic              remap_ok;
    logic [1:0]        order_eff;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    coef_entry_t       wr_data;
    ctl_t              ctl_next;

    logic              valid_reg;
    ctl_t              ctl_reg;
    logic [RAW_W-1:0]  x_reg;
    logic [X2_W-1:0]   x2_reg;
    logic [X2_W-1:0]   x2_next;

    // Index check
    assign op_c     = op_t'(op);
    assign in_range = ({1'b0, detector} < ND_L) && ({1'b0, strip} < NS_L);

    // Weave remap of the strip, applied to loads only
    always_comb
    begin
        chan = {1'b0, strip};
        if (weave_enable && (detector < DET_W'(WEAVE_DET_LIMIT)))
        begin
            if (strip[4])
                chan = {strip - STRIP_W'(WEAVE_OFFSET), 1'b0};
            else
                chan = {strip, 1'b1};
        end
        else if (weave_enable && back_weave_enable && (detector == DET_W'(BACK_DET)))
        begin
            if (strip < STRIP_W'(BACK_STRIPS))
                chan = CHAN_W'(BACK_TOP) - {1'b0, strip};
        end
    end
    assign remap_ok = (chan < NS_L);

    // Order zero evaluates as linear
    assign order_eff = (poly_order == ORDER_NONE) ? ORDER_LINEAR : poly_order;

    // Per-item control
    always_comb
    begin
        ctl_next          = '0;
        ctl_next.status   = ST_OK;
        ctl_next.energy   = (op_c == OP_ENERGY);
        ctl_next.use_sq   = (op_c == OP_ENERGY) && (order_eff >= ORDER_SQUARE);
        ctl_next.use_cube = (op_c == OP_ENERGY) && (order_eff == ORDER_CUBE);
        case (op_c)
            OP_LOAD:
            begin
                if (!in_range)
                    ctl_next.status = ST_RANGE;
                else if (!remap_ok)
                    ctl_next.status = ST_REMAP;
            end
            OP_ENERGY, OP_TIME:
            begin
                ctl_next.calc = in_range;
                if (!in_range)
                    ctl_next.status = ST_RANGE;
            end
            default:
            begin
                ctl_next.calc = 1'b0;
            end
        endcase
    end

    // Table addresses and write data
    assign wr_en   = adv && in_valid && (op_c == OP_LOAD) && in_range && remap_ok;
    assign wr_addr = AW'(int'(detector) * NUM_STRIPS + int'(chan));
    assign rd_addr = AW'(int'(detector) * NUM_STRIPS + int'(strip));

    always_comb
    begin
        wr_data.intercept = load_intercept;
        wr_data.slope     = load_slope;
        wr_data.square    = (poly_order >= ORDER_SQUARE) ? load_square : '0;
        wr_data.cube      = (poly_order == ORDER_CUBE) ? load_cube : '0;
    end

    // Coefficient memory: one write and one registered read per cycle while the pipeline advances.
    // A load writes at its own accept edge, so any later item reads the new entry.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            coef_mem[wr_addr] <= wr_data;
        if (adv)
            rd_data_reg <= coef_mem[rd_addr];
    end

    assign x2_next = raw_channel * raw_channel;

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg <= ctl_next;
            x_reg   <= raw_channel;
            x2_reg  <= x2_next;
        end
    end

    // Stage 1 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    assign s1_valid = valid_reg;
    assign s1_ctl   = ctl_reg;
    assign s1_x     = x_reg;
    assign s1_x2    = x2_reg;
    assign s1_coef  = rd_data_reg;

endmodule

[design/pccal_poly.sv]
// Polynomial evaluation pipeline: partial products and accumulation.
// Depends on pccal_pkg.
module pccal_poly #(
    parameter int COEFF_FRAC_BITS = pccal_pkg::DEF_COEFF_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              s1_valid,
    input  pccal_pkg::ctl_t                   s1_ctl,
    input  logic [pccal_pkg::RAW_W-1:0]        s1_x,
    input  logic [pccal_pkg::X2_W-1:0]         s1_x2,
    input  pccal_pkg::coef_entry_t            s1_coef,
    output logic                              acc_valid,
    output pccal_pkg::ctl_t                   acc_ctl,
    output logic signed [pccal_pkg::ACC_W-1:0] acc
);
    import pccal_pkg::*;

    localparam int SL_W  = COEF_W + RAW_W + 1;
    localparam int SQL_W = HALF_W + X2_W;
    localparam int SQH_W = HALF_W + X2_W + 1;
    localparam int CL_W  = 2 * HALF_W;
    localparam int CH_W  = 2 * HALF_W + 1;
    localparam int CA_W  = CH_W + CL_W;
    localparam int CM_W  = CH_W + 1;

    // Stage 2: linear and square partial products, x cubed
    logic                     v2_reg;
    ctl_t                     ctl2_reg;
    logic [RAW_W-1:0]         x2s_reg;
    logic signed [SL_W-1:0]   slope_x_reg;
    logic signed [SL_W-1:0]   slope_x_next;
    logic [SQL_W-1:0]         sq_lo_reg;
    logic [SQL_W-1:0]         sq_lo_next;
    logic signed [SQH_W-1:0]  sq_hi_reg;
    logic signed [SQH_W-1:0]  sq_hi_next;
    logic [X3_W-1:0]          x3_reg;
    logic [X3_W-1:0]          x3_next;
    logic signed [COEF_W-1:0] icpt_reg;
    logic [COEF_W-1:0]        cube_coef_reg;

    assign slope_x_next = $signed(s1_coef.slope) * $signed({1'b0, s1_x});
    assign sq_lo_next   = s1_coef.square[HALF_W-1:0] * s1_x2;
    assign sq_hi_next   = $signed(s1_coef.square[COEF_W-1:HALF_W]) * $signed({1'b0, s1_x2});
    assign x3_next      = s1_x2 * s1_x;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl2_reg      <= s1_ctl;
            x2s_reg       <= s1_x;
            slope_x_reg   <= slope_x_next;
            sq_lo_reg     <= sq_lo_next;
            sq_hi_reg     <= sq_hi_next;
            x3_reg        <= x3_next;
            icpt_reg      <= $signed(s1_coef.intercept);
            cube_coef_reg <= s1_coef.cube;
        end
    end

    // Stage 3: cube partial products, square term, intercept plus first term
    logic                    v3_reg;
    ctl_t                    ctl3_reg;
    logic [CL_W-1:0]         c_ll_reg;
    logic [CL_W-1:0]         c_ll_next;
    logic [CL_W-1:0]         c_lh_reg;
    logic [CL_W-1:0]         c_lh_next;
    logic signed [CH_W-1:0]  c_hl_reg;
    logic signed [CH_W-1:0]  c_hl_next;
    logic signed [CH_W-1:0]  c_hh_reg;
    logic signed [CH_W-1:0]  c_hh_next;
    logic signed [ACC_W-1:0] sq_reg;
    logic signed [ACC_W-1:0] sq_next;
    logic signed [ACC_W-1:0] sum1_reg;
    logic signed [ACC_W-1:0] sum1_next;
    logic signed [ACC_W-1:0] first_term;

    assign c_ll_next = cube_coef_reg[HALF_W-1:0] * x3_reg[HALF_W-1:0];
    assign c_lh_next = cube_coef_reg[HALF_W-1:0] * x3_reg[X3_W-1:HALF_W];
    assign c_hl_next = $signed(cube_coef_reg[COEF_W-1:HALF_W])
                       * $signed({1'b0, x3_reg[HALF_W-1:0]});
    assign c_hh_next = $signed(cube_coef_reg[COEF_W-1:HALF_W])
                       * $signed({1'b0, x3_reg[X3_W-1:HALF_W]});

    assign sq_next = (ACC_W'(sq_hi_reg) <<< HALF_W) + $signed(ACC_W'(sq_lo_reg));

    // Energy adds slope*x, time adds x at coefficient scale
    assign first_term = ctl2_reg.energy ? ACC_W'(slope_x_reg)
                                        : $signed(ACC_W'(x2s_reg) << COEFF_FRAC_BITS);
    assign sum1_next  = ACC_W'(icpt_reg) + first_term;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl3_reg <= ctl2_reg;
            c_ll_reg <= c_ll_next;
            c_lh_reg <= c_lh_next;
            c_hl_reg <= c_hl_next;
            c_hh_reg <= c_hh_next;
            sq_reg   <= sq_next;
            sum1_reg <= sum1_next;
        end
    end

    // Stage 4: cube cross terms, square term added
    logic                    v4_reg;
    ctl_t                    ctl4_reg;
    logic signed [CA_W-1:0]  cube_a_reg;
    logic signed [CM_W-1:0]  cube_mid_reg;
    logic signed [CM_W-1:0]  cube_mid_next;
    logic signed [ACC_W-1:0] sum2_reg;
    logic signed [ACC_W-1:0] sum2_next;

    assign cube_mid_next = $signed(CM_W'(c_lh_reg)) + CM_W'(c_hl_reg);
    assign sum2_next     = sum1_reg + (ctl3_reg.use_sq ? sq_reg : '0);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl4_reg     <= ctl3_reg;
            cube_a_reg   <= $signed({c_hh_reg, c_ll_reg});
            cube_mid_reg <= cube_mid_next;
            sum2_reg     <= sum2_next;
        end
    end

    // Stage 5: full cube term
    logic                    v5_reg;
    ctl_t                    ctl5_reg;
    logic signed [ACC_W-1:0] cube_reg;
    logic signed [ACC_W-1:0] cube_next;
    logic signed [ACC_W-1:0] sum2b_reg;

    assign cube_next = ACC_W'(cube_a_reg) + (ACC_W'(cube_mid_reg) <<< HALF_W);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl5_reg  <= ctl4_reg;
            cube_reg  <= cube_next;
            sum2b_reg <= sum2_reg;
        end
    end

    // Stage 6: final sum
    logic                    v6_reg;
    ctl_t                    ctl6_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    assign acc_next = sum2b_reg + (ctl5_reg.use_cube ? cube_reg : '0);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl6_reg <= ctl5_reg;
            acc_reg  <= acc_next;
        end
    end

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= s1_valid;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    assign acc_valid = v6_reg;
    assign acc_ctl   = ctl6_reg;
    assign acc       = acc_reg;

endmodule

[design/pccal_round.sv]
// Rounding to the result scale, saturation and the output register.
// Depends on pccal_pkg.
module pccal_round #(
    parameter int COEFF_FRAC_BITS  = pccal_pkg::DEF_COEFF_FRAC_BITS,
    parameter int RESULT_FRAC_BITS = pccal_pkg::DEF_RESULT_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              acc_valid,
    input  pccal_pkg::ctl_t                   acc_ctl,
    input  logic signed [pccal_pkg::ACC_W-1:0] acc,
    output logic                              out_valid,
    output logic [pccal_pkg::RES_W-1:0]        calibrated,
    output logic [1:0]                        status
);
    import pccal_pkg::*;

    localparam int SHIFT = COEFF_FRAC_BITS - RESULT_FRAC_BITS;
    localparam int RSH   = (SHIFT > 0) ? SHIFT : 0;
    localparam int LSH   = (SHIFT < 0) ? -SHIFT : 0;
    localparam int SW    = ACC_W + LSH + 1;

    localparam logic [SW-1:0]        ONE  = SW'(1);
    localparam logic signed [SW-1:0] HALF = $signed((ONE << RSH) >> 1);

    // Stage 7: round half up and rescale
    logic                 v7_reg;
    ctl_t                 ctl7_reg;
    logic signed [SW-1:0] scaled_reg;
    logic signed [SW-1:0] rounded;
    logic signed [SW-1:0] scaled_next;

    assign rounded     = SW'(acc) + HALF;
    assign scaled_next = (rounded >>> RSH) <<< LSH;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl7_reg   <= acc_ctl;
            scaled_reg <= scaled_next;
        end
    end

    // Stage 8: saturate into the output register
    logic [SW-RES_W:0]  top_bits;
    logic               fits;
    logic [RES_W-1:0]   calibrated_reg;
    logic [RES_W-1:0]   calibrated_next;
    status_t            status_reg;
    status_t            status_next;
    logic               out_valid_reg;

    assign top_bits = scaled_reg[SW-1:RES_W-1];
    assign fits     = (&top_bits) || !(|top_bits);

    always_comb
    begin
        if (!ctl7_reg.calc)
        begin
            calibrated_next = '0;
            status_next     = ctl7_reg.status;
        end
        else if (fits)
        begin
            calibrated_next = scaled_reg[RES_W-1:0];
            status_next     = ST_OK;
        end
        else
        begin
            calibrated_next = scaled_reg[SW-1] ? RES_MIN : RES_MAX;
            status_next     = ST_SAT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            calibrated_reg <= calibrated_next;
            status_reg     <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v7_reg        <= acc_valid;
            out_valid_reg <= v7_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign calibrated = calibrated_reg;
    assign status     = status_reg;

endmodule

[design/per_channel_polynomial_calibration.sv]
// Per-channel polynomial calibration: top level, configuration registers, pipeline control.
// Results pass the front, polynomial and rounding stages in order; an output stall holds them.
// Throughput: one beat per cycle unless stalled; the memory serves a write and a read a cycle.
// The pipeline moves as a whole; in_stall rises only while a result waits on out_stall.
// Reset clears the valid chain and sets poly_order 1, weaving off; the coefficient memory
// is not cleared and an entry is undefined until loaded.
module per_channel_polynomial_calibration #(
    parameter int NUM_DETECTORS    = pccal_pkg::DEF_NUM_DETECTORS,
    parameter int NUM_STRIPS       = pccal_pkg::DEF_NUM_STRIPS,
    parameter int COEFF_FRAC_BITS  = pccal_pkg::DEF_COEFF_FRAC_BITS,
    parameter int RESULT_FRAC_BITS = pccal_pkg::DEF_RESULT_FRAC_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pccal_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pccal_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     op,
    input  logic [pccal_pkg::DET_W-1:0]     detector,
    input  logic [pccal_pkg::STRIP_W-1:0]   strip,
    input  logic [pccal_pkg::RAW_W-1:0]     raw_channel,
    input  logic [pccal_pkg::COEF_W-1:0]    load_intercept,
    input  logic [pccal_pkg::COEF_W-1:0]    load_slope,
    input  logic [pccal_pkg::COEF_W-1:0]    load_square,
    input  logic [pccal_pkg::COEF_W-1:0]    load_cube,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [pccal_pkg::RES_W-1:0]     calibrated,
    output logic [1:0]                     status
);
    import pccal_pkg::*;

    logic [1:0] poly_order_reg;
    logic       weave_reg;
    logic       back_weave_reg;

    logic                    adv;
    logic                    s1_valid;
    ctl_t                    s1_ctl;
    logic [RAW_W-1:0]        s1_x;
    logic [X2_W-1:0]         s1_x2;
    coef_entry_t             s1_coef;
    logic                    acc_valid;
    ctl_t                    acc_ctl;
    logic signed [ACC_W-1:0] acc;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_order_reg <= ORDER_LINEAR;
            weave_reg      <= 1'b0;
            back_weave_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POLY_ORDER: poly_order_reg <= cfg_data;
                CFG_WEAVE:      weave_reg      <= cfg_data[0];
                CFG_BACK_WEAVE: back_weave_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Whole pipeline advances unless a finished result is held
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    pccal_front #(
        .NUM_DETECTORS (NUM_DETECTORS),
        .NUM_STRIPS    (NUM_STRIPS)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .adv               (adv),
        .in_valid          (in_valid),
        .op                (op),
        .detector          (detector),
        .strip             (strip),
        .raw_channel       (raw_channel),
        .load_intercept    (load_intercept),
        .load_slope        (load_slope),
        .load_square       (load_square),
        .load_cube         (load_cube),
        .poly_order        (poly_order_reg),
        .weave_enable      (weave_reg),
        .back_weave_enable (back_weave_reg),
        .s1_valid          (s1_valid),
        .s1_ctl            (s1_ctl),
        .s1_x              (s1_x),
        .s1_x2             (s1_x2),
        .s1_coef           (s1_coef)
    );

    pccal_poly #(
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .s1_valid  (s1_valid),
        .s1_ctl    (s1_ctl),
        .s1_x      (s1_x),
        .s1_x2     (s1_x2),
        .s1_coef   (s1_coef),
        .acc_valid (acc_valid),
        .acc_ctl   (acc_ctl),
        .acc       (acc)
    );

    pccal_round #(
        .COEFF_FRAC_BITS  (COEFF_FRAC_BITS),
        .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
    ) u_round (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .acc_valid  (acc_valid),
        .acc_ctl    (acc_ctl),
        .acc        (acc),
        .out_valid  (out_valid),
        .calibrated (calibrated),
        .status     (status)
    );

endmodule

[design/pccal_checker.sv]
// Port-level checks for the calibration block, attached to the top level by bind.
// Depends on pccal_pkg.
module pccal_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [pccal_pkg::RES_W-1:0]     calibrated,
    input logic [1:0]                     status
);
    import pccal_pkg::*;

    // A held result beat keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(calibrated) && $stable(status))
    else $error("held result beat changed");

    // Input backpressure only while a result is held
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
    else $error("input stall does not follow held output");

    // Saturation reports a limit value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_SAT) |-> (calibrated == RES_MAX) || (calibrated == RES_MIN))
    else $error("saturated status without a limit value");

    // Index errors carry a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((status == ST_RANGE) || (status == ST_REMAP)) |-> (calibrated == '0))
    else $error("index error with nonzero value");

endmodule

bind per_channel_polynomial_calibration pccal_checker u_pccal_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .calibrated (calibrated),
    .status     (status)
);

[tb/testbench.sv]
// Self-checking testbench for per_channel_polynomial_calibration.
// Depends on pccal_pkg and the block's top level. A scoreboard class predicts each
// beat's result from its own coefficient table; plain tasks drive traffic and config.
module testbench;
    import pccal_pkg::*;

    localparam int N_DET      = DEF_NUM_DETECTORS;
    localparam int N_STRIP    = DEF_NUM_STRIPS;
    localparam int CFB        = DEF_COEFF_FRAC_BITS;
    localparam int RFB        = DEF_RESULT_FRAC_BITS;
    localparam int SHIFT      = CFB - RFB;
    localparam int DEPTH      = N_DET * N_STRIP;
    localparam int LATENCY    = 7;
    localparam int CYCLE_CAP  = 400000;
    localparam int LONG_HOLD  = 150;

    localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic [COEF_W-1:0] HALF_LSB = 48'd1 << (SHIFT - 1);

    // 48-bit signed result window
    localparam logic signed [127:0] SUM_HI = (128'sd1 <<< (RES_W - 1)) - 128'sd1;
    localparam logic signed [127:0] SUM_LO = -(128'sd1 <<< (RES_W - 1));

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           op;
    logic [DET_W-1:0]     detector;
    logic [STRIP_W-1:0]   strip;
    logic [RAW_W-1:0]     raw_channel;
    logic [COEF_W-1:0]    load_intercept;
    logic [COEF_W-1:0]    load_slope;
    logic [COEF_W-1:0]    load_square;
    logic [COEF_W-1:0]    load_cube;
    logic                 out_valid;
    logic                 out_stall;
    logic [RES_W-1:0]     calibrated;
    logic [1:0]           status;

    per_channel_polynomial_calibration DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .detector       (detector),
        .strip          (strip),
        .raw_channel    (raw_channel),
        .load_intercept (load_intercept),
        .load_slope     (load_slope),
        .load_square    (load_square),
        .load_cube      (load_cube),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .calibrated     (calibrated),
        .status         (status)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    typedef struct {
        logic [RES_W-1:0] calibrated;
        status_t          status;
    } cal_result_t;

    // Coefficient table mirror, register copy and queue of expected results
    class cal_scoreboard;
        logic [COEF_W-1:0] icpt_mem   [DEPTH];
        logic [COEF_W-1:0] slope_mem  [DEPTH];
        logic [COEF_W-1:0] square_mem [DEPTH];
        logic [COEF_W-1:0] cube_mem   [DEPTH];
        logic [1:0]        poly_order;
        logic              weave_en;
        logic              back_weave_en;
        cal_result_t       pending_cal[$];
        int                errors;

        function new();
            poly_order    = ORDER_LINEAR;
            weave_en      = 1'b0;
            back_weave_en = 1'b0;
            errors        = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            case (idx)
                CFG_POLY_ORDER: poly_order = val;
                CFG_WEAVE:      weave_en = val[0];
                CFG_BACK_WEAVE: back_weave_en = val[0];
                default: ;
            endcase
        endfunction

        // Table slot a load would write under the current weave setting, -1 if none
        function int load_slot(logic [DET_W-1:0] det, logic [STRIP_W-1:0] strp);
            int chan;
            chan = strp;
            if (det >= N_DET || strp >= N_STRIP)
                return -1;
            if (weave_en && det < WEAVE_DET_LIMIT)
                chan = strp[4] ? (int'(strp) - WEAVE_OFFSET) * 2 : int'(strp) * 2 + 1;
            else if (weave_en && back_weave_en && det == BACK_DET && strp < BACK_STRIPS)
                chan = BACK_TOP - int'(strp);
            if (chan >= N_STRIP)
                return -1;
            return int'(det) * N_STRIP + chan;
        endfunction

        // Accepted input beat: update the table or evaluate the polynomial
        function void absorb_beat(op_t code, logic [DET_W-1:0] det,
                                  logic [STRIP_W-1:0] strp, logic [RAW_W-1:0] raw,
                                  logic [COEF_W-1:0] li, logic [COEF_W-1:0] ls,
                                  logic [COEF_W-1:0] lq, logic [COEF_W-1:0] lc);
            cal_result_t            res;
            int                     slot;
            logic [1:0]             order;
            logic signed [127:0]    sum;
            logic signed [127:0]    xv;
            res.calibrated = '0;
            res.status     = ST_OK;
            if (code == OP_NONE)
                res.status = ST_OK;
            else if (det >= N_DET || strp >= N_STRIP)
                res.status = ST_RANGE;
            else if (code == OP_LOAD)
            begin
                slot = load_slot(det, strp);
                if (slot < 0)
                    res.status = ST_REMAP;
                else
                begin
                    icpt_mem[slot]   = li;
                    slope_mem[slot]  = ls;
                    square_mem[slot] = (poly_order >= ORDER_SQUARE) ? lq : '0;
                    cube_mem[slot]   = (poly_order == ORDER_CUBE) ? lc : '0;
                end
            end
            else
            begin
                slot  = int'(det) * N_STRIP + int'(strp);
                order = (poly_order == ORDER_NONE) ? ORDER_LINEAR : poly_order;
                xv    = raw;
                sum   = $signed(icpt_mem[slot]);
                if (code == OP_ENERGY)
                begin
                    sum = sum + $signed(slope_mem[slot]) * xv;
                    if (order >= ORDER_SQUARE)
                        sum = sum + $signed(square_mem[slot]) * (xv * xv);
                    if (order == ORDER_CUBE)
                        sum = sum + $signed(cube_mem[slot]) * (xv * xv * xv);
                end
                else
                    sum = sum + (xv <<< CFB);
                // round half up into the result format, then clamp
                if (SHIFT > 0)
                    sum = (sum + (128'sd1 <<< (SHIFT - 1))) >>> SHIFT;
                else
                    sum = sum <<< (-SHIFT);
                if (sum > SUM_HI || sum < SUM_LO)
                begin
                    res.calibrated = sum[127] ? RES_MIN : RES_MAX;
                    res.status     = ST_SAT;
                end
                else
                    res.calibrated = sum[RES_W-1:0];
            end
            pending_cal.push_back(res);
        endfunction

        // Accepted result beat against the oldest expectation
        function void check_beat(logic [RES_W-1:0] cal_in, logic [1:0] st_in);
            cal_result_t exp_res;
            if (pending_cal.size() == 0)
            begin
                $display("%0t: result with nothing pending, calibrated %h status %0d",
                         $time, cal_in, st_in);
                errors++;
                return;
            end
            exp_res = pending_cal.pop_front();
            if (cal_in !== exp_res.calibrated)
            begin
                $display("%0t: calibrated expected %h actual %h",
                         $time, exp_res.calibrated, cal_in);
                errors++;
            end
            if (st_in !== exp_res.status)
            begin
                $display("%0t: status expected %0d actual %0d",
                         $time, exp_res.status, st_in);
                errors++;
            end
        endfunction
    endclass

    cal_scoreboard sb;
    bit            tx_steady;
    bit            rx_steady;
    int            rx_count;
    int            cycles;
    bit            loaded_map [DEPTH];
    int            loaded[$];
    int            last_slot;

    // Beat monitors on both channels
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.absorb_beat(op_t'(op), detector, strip, raw_channel, load_intercept,
                           load_slope, load_square, load_cube);
        if (rst_n && out_valid && !out_stall)
            sb.check_beat(calibrated, status);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: random stall per beat, steady stretches, two long hold-offs
    initial
    begin
        int hold;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            rx_steady = (rx_count % 200) >= 160;
            hold = rx_steady ? 0 : $urandom_range(0, 6);
            if (rx_count == 150 || rx_count == 600)
                hold = LONG_HOLD;
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
            rx_count++;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    // One input beat, preceded by a random gap unless in a steady stretch
    task automatic send_beat(input op_t code, input logic [DET_W-1:0] det,
                             input logic [STRIP_W-1:0] strp, input logic [RAW_W-1:0] raw,
                             input logic [COEF_W-1:0] li, input logic [COEF_W-1:0] ls,
                             input logic [COEF_W-1:0] lq, input logic [COEF_W-1:0] lc);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op             <= code;
        detector       <= det;
        strip          <= strp;
        raw_channel    <= raw;
        load_intercept <= li;
        load_slope     <= ls;
        load_square    <= lq;
        load_cube      <= lc;
        in_valid       <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    // Drain: wait for every pending result, then let the pipeline go quiet
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_cal.size() != 0) @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // Mostly magnitudes that keep the sum in range, some full-width and extremes
    function automatic logic [COEF_W-1:0] rand_coef(int mag);
        logic [63:0]       m;
        logic [COEF_W-1:0] v;
        m = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: v = m[COEF_W-1:0];
            1: v = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
            default:
            begin
                m = m & ((64'd1 << mag) - 64'd1);
                v = m[COEF_W-1:0];
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic logic [RAW_W-1:0] rand_raw();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return RAW_W'($urandom_range(0, 255));
            default: return RAW_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Random beat: loads, reads of loaded entries, out-of-range and unused ops
    task automatic random_beat();
        int               pick;
        int               det;
        int               strp;
        int               slot;
        bit               outside;
        op_t              code;
        logic [COEF_W-1:0] li;
        logic [COEF_W-1:0] ls;
        logic [COEF_W-1:0] lq;
        logic [COEF_W-1:0] lc;
        pick    = $urandom_range(0, 99);
        outside = $urandom_range(0, 9) == 0;
        li      = rand_coef(46);
        ls      = rand_coef(44);
        lq      = rand_coef(34);
        lc      = rand_coef(20);
        if (pick < 5)
            code = OP_NONE;
        else if (pick < 35 || loaded.size() == 0)
            code = OP_LOAD;
        else if (pick < 75)
            code = OP_ENERGY;
        else
            code = OP_TIME;

        if (code == OP_NONE)
        begin
            det  = $urandom_range(0, 15);
            strp = $urandom_range(0, 63);
        end
        else if (outside)
        begin
            det  = $urandom_range(0, N_DET - 1);
            strp = $urandom_range(0, N_STRIP - 1);
            if ($urandom_range(0, 1))
                det = $urandom_range(N_DET, 15);
            else
                strp = $urandom_range(N_STRIP, 63);
        end
        else if (code == OP_LOAD)
        begin
            det  = $urandom_range(0, N_DET - 1);
            strp = $urandom_range(0, N_STRIP - 1);
        end
        else
        begin
            // read back a loaded entry, often the one loaded last
            slot = ($urandom_range(0, 3) == 0) ? last_slot
                                               : loaded[$urandom_range(0, loaded.size() - 1)];
            det  = slot / N_STRIP;
            strp = slot % N_STRIP;
        end

        if (code == OP_LOAD)
        begin
            slot = sb.load_slot(DET_W'(det), STRIP_W'(strp));
            if (slot >= 0)
            begin
                if (!loaded_map[slot])
                    loaded.push_back(slot);
                loaded_map[slot] = 1'b1;
                last_slot = slot;
            end
        end
        send_beat(code, DET_W'(det), STRIP_W'(strp), rand_raw(), li, ls, lq, lc);
    endtask

    initial
    begin
        logic [1:0] order_sel;
        sb = new();
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_POLY_ORDER;
        cfg_data       <= '0;
        in_valid       <= 1'b0;
        op             <= OP_LOAD;
        detector       <= '0;
        strip          <= '0;
        raw_channel    <= '0;
        load_intercept <= '0;
        load_slope     <= '0;
        load_square    <= '0;
        load_cube      <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, saturation both ways, range errors, unused op, rounding
        write_reg(CFG_POLY_ORDER, ORDER_CUBE);
        write_reg(CFG_WEAVE, 2'd0);
        write_reg(CFG_BACK_WEAVE, 2'd0);
        send_beat(OP_LOAD, 4'd0, 6'd0, '0, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        send_beat(OP_ENERGY, 4'd0, 6'd0, '1, '0, '0, '0, '0);
        send_beat(OP_ENERGY, 4'd0, 6'd0, '0, '0, '0, '0, '0);
        send_beat(OP_LOAD, 4'd7, 6'd31, '0, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        send_beat(OP_ENERGY, 4'd7, 6'd31, '1, '0, '0, '0, '0);
        send_beat(OP_TIME, 4'd7, 6'd31, '1, '0, '0, '0, '0);
        send_beat(OP_TIME, 4'd0, 6'd0, '0, '0, '0, '0, '0);
        send_beat(OP_TIME, 4'd0, 6'd0, '1, '0, '0, '0, '0);
        send_beat(OP_ENERGY, 4'd8, 6'd0, '1, '0, '0, '0, '0);
        send_beat(OP_TIME, 4'd15, 6'd63, '1, '1, '1, '1, '1);
        send_beat(OP_LOAD, 4'd3, 6'd40, '0, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        send_beat(OP_NONE, 4'd15, 6'd63, '1, '1, '1, '1, '1);
        // exact half rounds up, negative half rounds to zero
        send_beat(OP_LOAD, 4'd2, 6'd2, '0, HALF_LSB, '0, '0, '0);
        send_beat(OP_ENERGY, 4'd2, 6'd2, '0, '0, '0, '0, '0);
        send_beat(OP_LOAD, 4'd2, 6'd3, '0, -HALF_LSB, '0, '0, '0);
        send_beat(OP_ENERGY, 4'd2, 6'd3, '0, '0, '0, '0, '0);
        // read right behind the write to the same entry
        send_beat(OP_LOAD, 4'd1, 6'd5, '0, rand_coef(46), rand_coef(44), rand_coef(34),
                  rand_coef(20));
        send_beat(OP_ENERGY, 4'd1, 6'd5, 16'd1000, '0, '0, '0, '0);
        settle();

        // Order zero with board weave and back-side reversal; high terms gated off
        write_reg(CFG_POLY_ORDER, ORDER_NONE);
        write_reg(CFG_WEAVE, 2'd1);
        write_reg(CFG_BACK_WEAVE, 2'd1);
        send_beat(OP_LOAD, 4'd0, 6'd20, '0, rand_coef(46), rand_coef(44), COEF_MAX, COEF_MAX);
        send_beat(OP_LOAD, 4'd4, 6'd2, '0, rand_coef(46), rand_coef(44), COEF_MAX, COEF_MAX);
        send_beat(OP_LOAD, 4'd4, 6'd10, '0, rand_coef(46), rand_coef(44), '0, '0);
        send_beat(OP_ENERGY, 4'd0, 6'd8, '1, '0, '0, '0, '0);
        send_beat(OP_ENERGY, 4'd4, 6'd5, 16'd300, '0, '0, '0, '0);
        settle();

        // Weave without back reversal keeps detector 4 strips as they are
        write_reg(CFG_POLY_ORDER, ORDER_SQUARE);
        write_reg(CFG_BACK_WEAVE, 2'd0);
        send_beat(OP_LOAD, 4'd4, 6'd2, '0, rand_coef(46), rand_coef(44), rand_coef(34),
                  rand_coef(20));
        send_beat(OP_ENERGY, 4'd4, 6'd2, 16'd5000, '0, '0, '0, '0);
        settle();

        // Random phases, each under its own register setting
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0, 4:    order_sel = ORDER_CUBE;
                1:       order_sel = ORDER_NONE;
                2:       order_sel = ORDER_LINEAR;
                default: order_sel = ORDER_SQUARE;
            endcase
            write_reg(CFG_POLY_ORDER, order_sel);
            write_reg(CFG_WEAVE, (p % 3 != 0) ? 2'd1 : 2'd0);
            write_reg(CFG_BACK_WEAVE, (p % 2 != 0) ? 2'd1 : 2'd0);
            for (int i = 0; i < 160; i++)
            begin
                tx_steady = (i % 60) >= 45;
                random_beat();
            end
            tx_steady = 1'b0;
            settle();
        end

        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
